### src/sme_pkg.sv
// Package for the stack machine execute unit: opcodes, status codes, FSM states,
// controller/datapath command and status structs. No dependencies.
package sme_pkg;

  localparam int unsigned StackDepthDef = 256;
  localparam int unsigned DataW = 32;
  localparam int unsigned IpW = 16;
  localparam int unsigned IpStep = 3;

  typedef enum logic [3:0] {
    OP_PUSH  = 4'd0,
    OP_POP   = 4'd1,
    OP_ADD   = 4'd2,
    OP_SUB   = 4'd3,
    OP_MUL   = 4'd4,
    OP_DIV   = 4'd5,
    OP_DUP   = 4'd6,
    OP_JMP   = 4'd7,
    OP_JZ    = 4'd8,
    OP_JNZ   = 4'd9,
    OP_SHOW  = 4'd10,
    OP_SWAP  = 4'd11,
    OP_EQ    = 4'd12,
    OP_LT    = 4'd13,
    OP_NOP14 = 4'd14,
    OP_NOP15 = 4'd15
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_UNDER = 3'd1,
    ST_OVER  = 3'd2,
    ST_DIVZ  = 3'd3,
    ST_JUMP  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,   // wait for start
    S_RD1,    // first stack read issued
    S_RD2,    // second stack read issued
    S_EXEC,   // operands present, compute and write
    S_DIV,    // iterative divide running
    S_WR2,    // second write (swap)
    S_DONE    // present result
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // latch input item
    logic rd_top;    // read entry sp-1
    logic rd_next;   // read entry sp-2
    logic lat_b;     // capture read data as b
    logic lat_a;     // capture read data as a
    logic exec;      // compute result and first write
    logic div_go;    // start divider
    logic wr2;       // swap second write
    logic finish;    // drive result strobe
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
    logic div_zero;  // latched top operand is zero
  } sts_t;

endpackage

### src/stack_machine_execute_unit.sv
// Stack machine execute unit: one instruction per start, one result strobe each.
// Sequence from the accepting edge: S_RD1, then S_RD2 for two-operand ops without
// underflow, S_EXEC, then S_DIV for div with a nonzero divisor (1 quotient bit per
// cycle) or S_WR2 for swap, and S_DONE with out_valid. Next start is accepted the
// cycle after out_valid; the stack memory's single read port sets the two-read
// sequence. Synchronous active-low reset empties the stack and clears program_limit;
// stack contents are not cleared. Results cannot stall.
// Depends on sme_pkg, sme_ctrl, sme_dp.
module stack_machine_execute_unit import sme_pkg::*; #(
  parameter int unsigned StackDepth = StackDepthDef
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [3:0]                      in_req_type,
  input  logic signed [DataW-1:0]         in_push_value,
  input  logic [IpW-1:0]                  in_cur_ip,
  input  logic [IpW-1:0]                  in_jump_target,
  output logic                            out_valid,
  output logic [2:0]                      out_status,
  output logic                            out_ip_write,
  output logic [IpW-1:0]                  out_next_ip,
  output logic                            out_print_valid,
  output logic signed [DataW-1:0]         out_print_value,
  output logic [$clog2(StackDepth+1)-1:0] out_stack_depth,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [IpW-1:0]                  cfg_program_limit
);

  ctl_t ctl;
  sts_t sts;
  logic [3:0] op;
  logic need_two, sts_ok;
  logic [IpW-1:0] limit_r;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '0;
    end else if (cfg_valid) begin
      limit_r <= cfg_program_limit;
    end
  end

  sme_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .op(op), .need_two(need_two),
    .sts_ok(sts_ok), .sts(sts), .ctl(ctl), .busy(busy)
  );

  sme_dp #(.StackDepth(StackDepth)) u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
    .in_req_type(in_req_type), .in_push_value(in_push_value),
    .in_cur_ip(in_cur_ip), .in_jump_target(in_jump_target), .limit(limit_r),
    .op(op), .need_two(need_two), .sts_ok(sts_ok),
    .out_status(out_status), .out_ip_write(out_ip_write), .out_next_ip(out_next_ip),
    .out_print_valid(out_print_valid), .out_print_value(out_print_value),
    .out_stack_depth(out_stack_depth)
  );

  assign out_valid = ctl.finish;

endmodule

### src/sme_ram.sv
// Generic single-port write, single read-port RAM with registered read.
// No dependencies.
module sme_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/sme_ctrl.sv
// Controller FSM for the stack machine execute unit.
// Depends on sme_pkg.
module sme_ctrl import sme_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic [3:0] op,
  input  logic     need_two,   // op reads two operands
  input  logic     sts_ok,     // no early error
  input  sts_t     sts,
  output ctl_t     ctl,
  output logic     busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (start) state_nxt = S_RD1;
      S_RD1: begin
        if (sts_ok && need_two) state_nxt = S_RD2;
        else state_nxt = S_EXEC;
      end
      S_RD2: state_nxt = S_EXEC;
      S_EXEC: begin
        if (op == OP_DIV && sts_ok && !sts.div_zero) state_nxt = S_DIV;
        else if (op == OP_SWAP && sts_ok) state_nxt = S_WR2;
        else state_nxt = S_DONE;
      end
      S_DIV: if (sts.div_done) state_nxt = S_DONE;
      S_WR2: state_nxt = S_DONE;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl = '0;
    busy = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: ctl.capture = start;
      S_RD1: begin
        ctl.lat_b = 1'b1;
        ctl.rd_next = 1'b1;
      end
      S_RD2: ctl.lat_a = 1'b1;
      S_EXEC: begin
        ctl.exec = 1'b1;
        ctl.div_go = (op == OP_DIV) && sts_ok && !sts.div_zero;
      end
      S_DIV: ;
      S_WR2: ctl.wr2 = 1'b1;
      S_DONE: ctl.finish = 1'b1;
      default: ;
    endcase
    ctl.rd_top = ctl.capture;
  end

endmodule

### src/sme_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating.
// Depends on sme_pkg.
module sme_div import sme_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [DataW-1:0] dividend,
  input  logic [DataW-1:0] divisor,
  output logic             done,
  output logic [DataW-1:0] quotient
);

  localparam int unsigned CntW = $clog2(DataW + 1);

  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic [DataW-1:0] q_r, q_nxt;
  logic [DataW:0]   rem_r, rem_nxt;
  logic [DataW-1:0] dvs_r, dvs_nxt;
  logic             neg_r, neg_nxt;
  logic [DataW:0]   trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  // restoring division on magnitudes
  always_comb begin
    run_nxt = run_r;
    cnt_nxt = cnt_r;
    q_nxt   = q_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    neg_nxt = neg_r;
    trial   = {rem_r[DataW-1:0], q_r[DataW-1]} - {1'b0, dvs_r};
    done    = 1'b0;
    if (go) begin
      run_nxt = 1'b1;
      cnt_nxt = CntW'(DataW);
      q_nxt   = dividend[DataW-1] ? (~dividend + 1'b1) : dividend;
      dvs_nxt = divisor[DataW-1] ? (~divisor + 1'b1) : divisor;
      rem_nxt = '0;
      neg_nxt = dividend[DataW-1] ^ divisor[DataW-1];
    end else if (run_r) begin
      if (cnt_r == '0) begin
        run_nxt = 1'b0;
        done = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
        if (!trial[DataW]) begin
          rem_nxt = trial;
          q_nxt = {q_r[DataW-2:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[DataW-1:0], q_r[DataW-1]};
          q_nxt = {q_r[DataW-2:0], 1'b0};
        end
      end
    end
  end

  assign quotient = neg_r ? (~q_r + 1'b1) : q_r;

endmodule

### src/sme_dp.sv
// Datapath: stack memory, stack pointer, operand registers, ALU, result regs.
// Depends on sme_pkg, sme_ram, sme_div.
module sme_dp import sme_pkg::*; #(
  parameter int unsigned StackDepth = StackDepthDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ctl_t                         ctl,
  output sts_t                         sts,
  input  logic [3:0]                   in_req_type,
  input  logic signed [DataW-1:0]      in_push_value,
  input  logic [IpW-1:0]               in_cur_ip,
  input  logic [IpW-1:0]               in_jump_target,
  input  logic [IpW-1:0]               limit,
  output logic [3:0]                   op,
  output logic                         need_two,
  output logic                         sts_ok,
  output logic [2:0]                   out_status,
  output logic                         out_ip_write,
  output logic [IpW-1:0]               out_next_ip,
  output logic                         out_print_valid,
  output logic signed [DataW-1:0]      out_print_value,
  output logic [$clog2(StackDepth+1)-1:0] out_stack_depth
);

  localparam int unsigned AW = $clog2(StackDepth);
  localparam int unsigned SpW = $clog2(StackDepth + 1);
  localparam logic [SpW-1:0] Full = SpW'(StackDepth);

  logic [3:0]       op_r;
  logic [DataW-1:0] pv_r, a_r, b_r;
  logic [IpW-1:0]   ip_r, tgt_r;
  logic [SpW-1:0]   sp_r, sp_nxt;
  logic [2:0]       st_r, st_nxt;
  logic             ipw_r, ipw_nxt, pvld_r, pvld_nxt;
  logic [IpW-1:0]   nip_r, nip_nxt;
  logic [DataW-1:0] pval_r, pval_nxt;
  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [DataW-1:0] wdata, rdata;
  logic             div_done;
  logic [DataW-1:0] quo;
  logic             jump_bad;
  logic [DataW-1:0] prod_r;

  sme_ram #(.Width(DataW), .Depth(StackDepth)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  sme_div u_div (
    .clk(clk), .rst_n(rst_n), .go(ctl.div_go), .dividend(a_r), .divisor(b_r),
    .done(div_done), .quotient(quo)
  );

  assign sts = '{div_done: div_done, div_zero: (b_r == '0)};
  assign op = op_r;
  assign jump_bad = (tgt_r >= limit);
  assign need_two = (op_r inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SWAP, OP_EQ, OP_LT});

  // underflow guard for two-operand ops
  assign sts_ok = !(need_two && sp_r < SpW'(2));

  // read address: top at capture uses live sp, next one after
  assign raddr = ctl.rd_top ? AW'(sp_r - 1'b1) : AW'(sp_r - SpW'(2));

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      op_r  <= in_req_type;
      pv_r  <= in_push_value;
      ip_r  <= in_cur_ip;
      tgt_r <= in_jump_target;
    end
    if (ctl.lat_b) b_r <= rdata;
    if (ctl.lat_a) a_r <= rdata;
    prod_r <= a_r * b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
      st_r <= ST_OK;
      ipw_r <= 1'b0;
      nip_r <= '0;
      pvld_r <= 1'b0;
      pval_r <= '0;
    end else begin
      sp_r <= sp_nxt;
      st_r <= st_nxt;
      ipw_r <= ipw_nxt;
      nip_r <= nip_nxt;
      pvld_r <= pvld_nxt;
      pval_r <= pval_nxt;
    end
  end

  // execute: stack updates and result fields
  always_comb begin
    sp_nxt = sp_r;
    st_nxt = st_r;
    ipw_nxt = ipw_r;
    nip_nxt = nip_r;
    pvld_nxt = pvld_r;
    pval_nxt = pval_r;
    we = 1'b0;
    waddr = AW'(sp_r);
    wdata = pv_r;
    if (ctl.capture) begin
      st_nxt = ST_OK; ipw_nxt = 1'b0; nip_nxt = '0; pvld_nxt = 1'b0; pval_nxt = '0;
    end
    if (ctl.exec) begin
      case (op_r)
        OP_PUSH: begin
          if (sp_r >= Full) st_nxt = ST_OVER;
          else begin we = 1'b1; sp_nxt = sp_r + 1'b1; end
        end
        OP_POP: begin
          if (sp_r == '0) st_nxt = ST_UNDER;
          else sp_nxt = sp_r - 1'b1;
        end
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_LT: begin
          if (sp_r < SpW'(2)) begin
            st_nxt = ST_UNDER;
            if (sp_r != '0 && op_r != OP_EQ && op_r != OP_LT) sp_nxt = '0;
          end else if (op_r == OP_DIV) begin
            sp_nxt = sp_r - SpW'(2);
            if (b_r == '0) st_nxt = ST_DIVZ;
          end else if (op_r == OP_MUL) begin
            sp_nxt = sp_r - SpW'(2);
          end else begin
            we = 1'b1;
            waddr = AW'(sp_r - SpW'(2));
            sp_nxt = sp_r - 1'b1;
            case (op_r)
              OP_ADD: wdata = a_r + b_r;
              OP_SUB: wdata = a_r - b_r;
              OP_EQ:  wdata = DataW'(a_r == b_r);
              OP_LT:  wdata = DataW'($signed(a_r) < $signed(b_r));
              default: wdata = a_r;
            endcase
          end
        end
        OP_DUP: begin
          if (sp_r == '0) st_nxt = ST_UNDER;
          else if (sp_r >= Full) st_nxt = ST_OVER;
          else begin we = 1'b1; wdata = b_r; sp_nxt = sp_r + 1'b1; end
        end
        OP_JMP: begin
          if (jump_bad) st_nxt = ST_JUMP;
          else begin ipw_nxt = 1'b1; nip_nxt = tgt_r; end
        end
        OP_JZ, OP_JNZ: begin
          if (jump_bad) st_nxt = ST_JUMP;
          else if (sp_r == '0) st_nxt = ST_UNDER;
          else begin
            sp_nxt = sp_r - 1'b1;
            ipw_nxt = 1'b1;
            if ((op_r == OP_JZ) == (b_r == '0)) nip_nxt = tgt_r;
            else nip_nxt = ip_r + IpW'(IpStep);
          end
        end
        OP_SHOW: begin
          if (sp_r == '0) st_nxt = ST_UNDER;
          else begin sp_nxt = sp_r - 1'b1; pvld_nxt = 1'b1; pval_nxt = b_r; end
        end
        OP_SWAP: begin
          if (sp_r < SpW'(2)) st_nxt = ST_UNDER;
          else begin we = 1'b1; waddr = AW'(sp_r - SpW'(2)); wdata = b_r; end
        end
        default: ;
      endcase
    end
    // product is registered from the operands; written in done state
    if (ctl.finish && op_r == OP_MUL && st_r == ST_OK) begin
      we = 1'b1; waddr = AW'(sp_r); wdata = prod_r; sp_nxt = sp_r + 1'b1;
    end
    if (div_done && st_r == ST_OK) begin
      we = 1'b1; waddr = AW'(sp_r); wdata = quo; sp_nxt = sp_r + 1'b1;
    end
    if (ctl.wr2) begin
      we = 1'b1; waddr = AW'(sp_r - 1'b1); wdata = a_r;
    end
  end

  // result ports: mul pushes in the same edge, so depth is reported +1
  assign out_status = st_r;
  assign out_ip_write = ipw_r;
  assign out_next_ip = nip_r;
  assign out_print_valid = pvld_r;
  assign out_print_value = pval_r;
  assign out_stack_depth = (ctl.finish && op_r == OP_MUL && st_r == ST_OK) ?
                           sp_r + 1'b1 : sp_r;

endmodule

### src/sme_checker.sv
// Port-level checker for the stack machine execute unit, bound to the top.
// Depends on sme_pkg.
module sme_checker import sme_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [2:0] out_status,
  input logic       out_ip_write,
  input logic       out_print_valid
);

  // an accepted item raises busy
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised");

  // result strobe lasts one cycle
  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("strobe too long");

  // result only while busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");

  // an error result carries no jump and no print
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> !out_ip_write && !out_print_valid)
    else $error("side output on error");

endmodule

bind stack_machine_execute_unit sme_checker u_sme_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_status(out_status), .out_ip_write(out_ip_write),
  .out_print_valid(out_print_valid)
);
